// File: hdl/iir8_pkg.sv
// Shared constants, coefficient tables and command types for the order-8 IIR core.
package iir8_pkg;

  localparam int FILTER_ORDER      = 8;
  localparam int COEF_FRAC_BITS    = 40;
  localparam int HISTORY_FRAC_BITS = 28;
  localparam int GAIN_FRAC_BITS    = 8;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 12;
  localparam int HIST_W   = 48;
  localparam int COEF_W   = 48;
  localparam int HALF_W   = HIST_W / 2;
  localparam int MUL_W    = HALF_W + 1;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 100;
  localparam int MAG_W    = 24;
  localparam int TAP_W    = $clog2(FILTER_ORDER + 1);
  localparam int HIDX_W   = $clog2(FILTER_ORDER);

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(640);

  typedef enum logic [1:0] {
    SRC_FF   = 2'd0,
    SRC_FB   = 2'd1,
    SRC_GAIN = 2'd2
  } iir8_src_t;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_HALF = 2'd1,
    SH_FULL = 2'd2,
    SH_FF = 2'd3
  } iir8_shift_t;

  typedef struct packed {
    logic             load_x;
    logic             mul_en;
    iir8_src_t        mul_src;
    logic [TAP_W-1:0] tap;
    logic [1:0]       part;
    logic             update;
    logic             emit;
  } iir8_cmd_t;

  // decimal constant times 2^COEF_FRAC_BITS, rounded half away from zero
  function automatic logic signed [COEF_W-1:0] quantize(input logic [63:0] mant,
                                                        input logic [63:0] den,
                                                        input logic        neg);
    logic [127:0] num;
    logic [64:0]  rem;
    logic [63:0]  q;
    int           i;
    num = {64'd0, mant} << COEF_FRAC_BITS;
    rem = '0;
    q   = '0;
    for (i = 127; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        if (i < 64) begin
          q = q | (64'd1 << i);
        end
      end
    end
    if (rem >= ({1'b0, den} - rem)) begin
      q = q + 64'd1;
    end
    return neg ? COEF_W'(-q) : COEF_W'(q);
  endfunction

  localparam logic [63:0] DEN18 = 64'd1000000000000000000;
  localparam logic [63:0] DEN15 = 64'd1000000000000000;
  localparam logic [63:0] DEN14 = 64'd100000000000000;
  localparam logic [63:0] DEN13 = 64'd10000000000000;

  localparam logic signed [COEF_W-1:0] FF_COEF [0:FILTER_ORDER] = '{
    quantize(64'd28379052251, DEN18, 1'b0),
    quantize(64'd0, 64'd1, 1'b0),
    quantize(64'd113516209005, DEN18, 1'b1),
    quantize(64'd0, 64'd1, 1'b0),
    quantize(64'd170274313507, DEN18, 1'b0),
    quantize(64'd0, 64'd1, 1'b0),
    quantize(64'd113516209005, DEN18, 1'b1),
    quantize(64'd0, 64'd1, 1'b0),
    quantize(64'd28379052251, DEN18, 1'b0)
  };

  localparam logic signed [COEF_W-1:0] FB_COEF [0:FILTER_ORDER] = '{
    quantize(64'd0, 64'd1, 1'b0),
    quantize(64'd792139814864085, DEN14, 1'b1),
    quantize(64'd274628690203029, DEN13, 1'b0),
    quantize(64'd544271942671112, DEN13, 1'b1),
    quantize(64'd674419254163037, DEN13, 1'b0),
    quantize(64'd535042025245989, DEN13, 1'b1),
    quantize(64'd265393236487168, DEN13, 1'b0),
    quantize(64'd752519713333643, DEN14, 1'b1),
    quantize(64'd933873988406161, DEN15, 1'b0)
  };

endpackage

// File: hdl/iir_filter_order8_direct_form_one_core.sv
// Top level of the eighth-order direct form I IIR filter with output gain.
//
// Input channel in_valid/in_ready carries one signed 16-bit sample word.
// Output channel out_valid/out_ready carries the filtered sample times the
// gain (truncated toward zero, saturated) and a clip flag.
// cfg_wr_en/cfg_wr_data write the 12-bit unsigned Q4.8 output gain; write only
// while the core is idle.
// One word is processed at a time on a single shared 25x25 multiplier: nine
// feed-forward taps are one product each, eight feedback taps are four
// partial products each, plus two gain products and pipeline drain cycles.
// A new word is accepted only in the idle state, once the previous result has
// been written to the output register.
// The result sits in an output register; if the receiver stalls, the core
// still accepts and works on the next word and only waits at its final step
// until the previous result is taken.
// Synchronous reset clears both sample histories and sets the gain to 2.5.
module iir_filter_order8_direct_form_one_core
  import iir8_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_clipped,
  input  logic                       cfg_wr_en,
  input  logic [GAIN_W-1:0]          cfg_wr_data
);

  iir8_cmd_t cmd;
  logic      out_busy;

  iir8_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_busy (out_busy),
    .cmd      (cmd)
  );

  iir8_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_sample_in   (in_sample_in),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped),
    .out_busy       (out_busy)
  );

endmodule

// File: hdl/iir8_ctrl.sv
// Sequencer for the order-8 IIR core: steps taps and partial products, then output.
module iir8_ctrl
  import iir8_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_busy,
  output iir8_cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_FF     = 8'b0000_0010,
    ST_FB     = 8'b0000_0100,
    ST_DRAIN  = 8'b0000_1000,
    ST_SAT    = 8'b0001_0000,
    ST_GAIN   = 8'b0010_0000,
    ST_GDRAIN = 8'b0100_0000,
    ST_OUT    = 8'b1000_0000
  } iir8_state_t;

  iir8_state_t      state_r, state_nxt;
  logic [TAP_W-1:0] tap_r, tap_nxt;
  logic [1:0]       part_r, part_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    part_nxt  = part_r;
    cmd       = '0;
    cmd.tap   = tap_r;
    cmd.part  = part_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_x = 1'b1;
          tap_nxt    = '0;
          state_nxt  = ST_FF;
        end
      end
      ST_FF: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = SRC_FF;
        if (tap_r == TAP_W'(FILTER_ORDER)) begin
          tap_nxt   = TAP_W'(1);
          part_nxt  = '0;
          state_nxt = ST_FB;
        end else begin
          tap_nxt = tap_r + TAP_W'(1);
        end
      end
      ST_FB: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = SRC_FB;
        part_nxt    = part_r + 2'd1;
        if (part_r == 2'd3) begin
          if (tap_r == TAP_W'(FILTER_ORDER)) begin
            state_nxt = ST_DRAIN;
          end else begin
            tap_nxt = tap_r + TAP_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        cmd.update = 1'b1;
        part_nxt   = '0;
        state_nxt  = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = SRC_GAIN;
        part_nxt    = part_r + 2'd1;
        if (part_r[0]) begin
          state_nxt = ST_GDRAIN;
        end
      end
      ST_GDRAIN: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= '0;
      part_r  <= '0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      part_r  <= part_nxt;
    end
  end

endmodule

// File: hdl/iir8_dp.sv
// Datapath for the order-8 IIR core: histories, shared multiplier, accumulator, output word.
module iir8_dp
  import iir8_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  iir8_cmd_t                  cmd,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic                       cfg_wr_en,
  input  logic [GAIN_W-1:0]          cfg_wr_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_clipped,
  output logic                       out_busy
);

  localparam int YHI_LSB = COEF_FRAC_BITS + HIST_W - 1;
  localparam int MAG_LSB = HISTORY_FRAC_BITS + GAIN_FRAC_BITS;

  logic [GAIN_W-1:0]          gain_r;
  logic signed [SAMPLE_W-1:0] x_cur_r;
  logic signed [SAMPLE_W-1:0] x_hist_r [0:FILTER_ORDER-1];
  logic signed [HIST_W-1:0]   y_hist_r [0:FILTER_ORDER-1];
  logic [HIST_W-1:0]          mag_r;
  logic                       neg_r;

  logic signed [PROD_W-1:0]   prod_r;
  iir8_shift_t                prod_sh_r;
  logic                       prod_sub_r;
  logic                       prod_vld_r;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                       clip_r, clip_nxt;

  logic [HIDX_W-1:0]          hidx;
  logic signed [SAMPLE_W-1:0] x_sel;
  logic signed [HIST_W-1:0]   y_sel;
  logic signed [COEF_W-1:0]   c_ff, c_fb;
  logic signed [MUL_W-1:0]    op_a, op_b;
  logic signed [PROD_W-1:0]   prod;
  iir8_shift_t                sh;
  logic                       sub;

  logic signed [ACC_W-1:0]    term_ext, term;
  logic [ACC_W-YHI_LSB-1:0]   y_top;
  logic signed [HIST_W-1:0]   ynew;
  logic [HIST_W-1:0]          ymag;
  logic [MAG_W-1:0]           mag_out;

  assign out_busy       = out_valid_r & ~out_ready;
  assign out_valid      = out_valid_r;
  assign out_sample_out = sample_r;
  assign out_clipped    = clip_r;

  // operand select for the shared 25x25 multiplier
  always_comb begin
    hidx  = HIDX_W'(cmd.tap - TAP_W'(1));
    x_sel = (cmd.tap == '0) ? x_cur_r : x_hist_r[hidx];
    y_sel = y_hist_r[hidx];
    c_ff  = FF_COEF[cmd.tap];
    c_fb  = FB_COEF[cmd.tap];
    op_a  = '0;
    op_b  = '0;
    sh    = SH_0;
    sub   = 1'b0;
    case (cmd.mul_src)
      SRC_FF: begin
        op_a = {{(MUL_W-SAMPLE_W){x_sel[SAMPLE_W-1]}}, x_sel};
        op_b = c_ff[MUL_W-1:0];
        sh   = SH_FF;
      end
      SRC_FB: begin
        op_a = cmd.part[1] ? {y_sel[HIST_W-1], y_sel[HIST_W-1:HALF_W]}
                           : {1'b0, y_sel[HALF_W-1:0]};
        op_b = cmd.part[0] ? {c_fb[COEF_W-1], c_fb[COEF_W-1:HALF_W]}
                           : {1'b0, c_fb[HALF_W-1:0]};
        case (cmd.part)
          2'd0:    sh = SH_0;
          2'd3:    sh = SH_FULL;
          default: sh = SH_HALF;
        endcase
        sub = 1'b1;
      end
      SRC_GAIN: begin
        op_a = cmd.part[0] ? {1'b0, mag_r[HIST_W-1:HALF_W]} : {1'b0, mag_r[HALF_W-1:0]};
        op_b = {{(MUL_W-GAIN_W){1'b0}}, gain_r};
        sh   = cmd.part[0] ? SH_HALF : SH_0;
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign prod = op_a * op_b;

  always_comb begin
    term_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    case (prod_sh_r)
      SH_0:    term = term_ext;
      SH_HALF: term = term_ext <<< HALF_W;
      SH_FULL: term = term_ext <<< HIST_W;
      SH_FF:   term = term_ext <<< HISTORY_FRAC_BITS;
      default: term = term_ext;
    endcase
    acc_nxt = prod_sub_r ? (acc_r - term) : (acc_r + term);
  end

  // new output history value: floor shift, then saturate to the history width
  always_comb begin
    y_top = acc_r[ACC_W-1:YHI_LSB];
    if ((y_top == '0) || (y_top == '1)) begin
      ynew = acc_r[YHI_LSB:COEF_FRAC_BITS];
    end else begin
      ynew = acc_r[ACC_W-1] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
    end
    ymag = ynew[HIST_W-1] ? HIST_W'(-ynew) : HIST_W'(ynew);
  end

  always_comb begin
    mag_out = acc_r[MAG_LSB +: MAG_W];
    if (neg_r) begin
      if (mag_out > MAG_W'(32768)) begin
        sample_nxt = {1'b1, {(SAMPLE_W-1){1'b0}}};
        clip_nxt   = 1'b1;
      end else begin
        sample_nxt = SAMPLE_W'(-mag_out[SAMPLE_W-1:0]);
        clip_nxt   = 1'b0;
      end
    end else begin
      if (mag_out > MAG_W'(32767)) begin
        sample_nxt = {1'b0, {(SAMPLE_W-1){1'b1}}};
        clip_nxt   = 1'b1;
      end else begin
        sample_nxt = mag_out[SAMPLE_W-1:0];
        clip_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RESET;
      prod_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < FILTER_ORDER; i++) begin
        x_hist_r[i] <= '0;
        y_hist_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
      prod_vld_r <= cmd.mul_en;
      if (cmd.update) begin
        for (int i = FILTER_ORDER - 1; i > 0; i--) begin
          x_hist_r[i] <= x_hist_r[i-1];
          y_hist_r[i] <= y_hist_r[i-1];
        end
        x_hist_r[0] <= x_cur_r;
        y_hist_r[0] <= ynew;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod;
    prod_sh_r  <= sh;
    prod_sub_r <= sub;
    if (cmd.load_x) begin
      x_cur_r <= in_sample_in;
    end
    if (cmd.load_x || cmd.update) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_nxt;
    end
    if (cmd.update) begin
      mag_r <= ymag;
      neg_r <= ynew[HIST_W-1];
    end
    if (cmd.emit) begin
      sample_r <= sample_nxt;
      clip_r   <= clip_nxt;
    end
  end

endmodule
